// ===== design/psme_pkg.sv =====
// Shared widths, codes and types of the partition sum move evaluator.
package psme_pkg;

    localparam int ITEM_W       = 8;
    localparam int ITEM_RANGE   = 1 << ITEM_W;
    localparam int TGT_W        = 3;
    localparam int TGT_RANGE    = 1 << TGT_W;
    localparam int LEAD_W       = 2;
    localparam int LEAD_RANGE   = 1 << LEAD_W;
    localparam int VAL_W        = 16;
    localparam int VALUE_FIELDS = 4;
    localparam int SUM_W        = 24;
    localparam int CNT_W        = 9;
    localparam int STATUS_W     = 2;

    localparam int DEF_NUM_ITEMS = 256;
    localparam int DEF_NUM_PARTS = 8;
    localparam int DEF_NUM_DIMS  = 4;

    typedef enum logic {
        ACT_PLACE = 1'b0,
        ACT_MOVE  = 1'b1
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE          = 2'd0,
        ST_MOVE_UNPLACED = 2'd1,
        ST_PLACE_PLACED  = 2'd2
    } t_status;

    typedef struct packed {
        logic add;
        logic sub;
    } t_lane_ctl;

endpackage

// ===== design/psme_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface psme_in_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [psme_pkg::ITEM_W-1:0]    item;
    logic [psme_pkg::TGT_W-1:0]     target_part;
    logic [psme_pkg::VAL_W-1:0]     value_0;
    logic [psme_pkg::VAL_W-1:0]     value_1;
    logic [psme_pkg::VAL_W-1:0]     value_2;
    logic [psme_pkg::VAL_W-1:0]     value_3;

    modport source (
        output valid, action, item, target_part, value_0, value_1, value_2, value_3,
        input  ready
    );
    modport sink (
        input  valid, action, item, target_part, value_0, value_1, value_2, value_3,
        output ready
    );
endinterface

interface psme_out_if;
    logic                           valid;
    logic                           ready;
    logic [psme_pkg::STATUS_W-1:0]  status;
    logic [psme_pkg::TGT_W-1:0]     chosen_part;
    logic [psme_pkg::TGT_W-1:0]     source_part;
    logic [psme_pkg::CNT_W-1:0]     source_count;
    logic [psme_pkg::SUM_W-1:0]     fitness;

    modport source (
        output valid, status, chosen_part, source_part, source_count, fitness,
        input  ready
    );
    modport sink (
        input  valid, status, chosen_part, source_part, source_count, fitness,
        output ready
    );
endinterface

// ===== design/partition_sum_move_evaluator.sv =====
// Top level of the partition sum move evaluator.
// Keeps each item's part, and per part an item count and per-dimension sums, in one lane
// per part. An item is accepted only while the block is idle, and its result is held back
// while the previous result has not yet been taken; the next item can be accepted as soon
// as that result is registered, so no new item is taken before the last one is through.
// Between acceptance and result lie the read of the item's part from the item RAM, the lane
// update, the two-stage merge (min/max tree, then fitness) and the output register. A result
// waiting on the output does not block acceptance of the next item. Item and part indices are
// taken modulo NUM_ITEMS and NUM_PARTS, the lead dimension modulo NUM_DIMS. There is no clearing
// pass after reset: placement is tracked by per-item valid bits cleared by reset.
module partition_sum_move_evaluator #(
    parameter int NUM_ITEMS = psme_pkg::DEF_NUM_ITEMS,
    parameter int NUM_PARTS = psme_pkg::DEF_NUM_PARTS,
    parameter int NUM_DIMS  = psme_pkg::DEF_NUM_DIMS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [psme_pkg::LEAD_W-1:0]  i_cfg_data,
    psme_in_if.sink                      i_in,
    psme_out_if.source                   o_out
);

    localparam int ITEM_DEPTH = (NUM_ITEMS < psme_pkg::ITEM_RANGE) ? NUM_ITEMS
                                                                   : psme_pkg::ITEM_RANGE;
    localparam int IAW = $clog2(ITEM_DEPTH);
    localparam int PW  = $clog2(NUM_PARTS);
    localparam int DW  = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DEC    = 5'b00010,
        S_SETTLE = 5'b00100,
        S_FIT    = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [psme_pkg::LEAD_W-1:0] r_lead;

    logic [IAW-1:0] w_item_map [psme_pkg::ITEM_RANGE];
    logic [PW-1:0]  w_tgt_map  [psme_pkg::TGT_RANGE];
    logic [DW-1:0]  w_lead_map [psme_pkg::LEAD_RANGE];

    logic [psme_pkg::VAL_W-1:0] w_in_fields [psme_pkg::VALUE_FIELDS];
    logic [psme_pkg::VAL_W-1:0] w_in_vals   [NUM_DIMS];

    psme_pkg::t_action          r_action;
    logic [IAW-1:0]             r_item;
    logic [PW-1:0]              r_target;
    logic [psme_pkg::VAL_W-1:0] r_vals [NUM_DIMS];

    logic                   r_placed [ITEM_DEPTH];
    logic                   w_accept;
    logic                   w_placed;
    logic [PW-1:0]          w_cur;
    logic [PW-1:0]          w_best;
    psme_pkg::t_status      w_status;
    logic [PW-1:0]          w_chosen;
    logic [PW-1:0]          w_src;
    logic                   w_upd;
    logic                   w_commit;
    logic                   w_moved;
    psme_pkg::t_lane_ctl    w_ctl [NUM_PARTS];

    psme_pkg::t_status      r_status;
    logic [PW-1:0]          r_chosen;
    logic [PW-1:0]          r_src;
    logic                   r_moved;

    logic [psme_pkg::CNT_W-1:0] w_count [NUM_PARTS];
    logic [psme_pkg::SUM_W-1:0] w_sums  [NUM_PARTS][NUM_DIMS];
    logic [psme_pkg::SUM_W-1:0] w_fitness;

    logic                          r_out_valid;
    logic [psme_pkg::STATUS_W-1:0] r_out_status;
    logic [psme_pkg::TGT_W-1:0]    r_out_chosen;
    logic [psme_pkg::TGT_W-1:0]    r_out_src;
    logic [psme_pkg::CNT_W-1:0]    r_out_count;
    logic [psme_pkg::SUM_W-1:0]    r_out_fitness;
    logic                          w_load;

    // index reduction tables
    for (genvar g = 0; g < psme_pkg::ITEM_RANGE; g++) begin : g_item_map
        localparam int unsigned M = g % ITEM_DEPTH;
        assign w_item_map[g] = IAW'(M);
    end
    for (genvar g = 0; g < psme_pkg::TGT_RANGE; g++) begin : g_tgt_map
        localparam int unsigned M = g % NUM_PARTS;
        assign w_tgt_map[g] = PW'(M);
    end
    for (genvar g = 0; g < psme_pkg::LEAD_RANGE; g++) begin : g_lead_map
        localparam int unsigned M = g % NUM_DIMS;
        assign w_lead_map[g] = DW'(M);
    end

    assign w_in_fields[0] = i_in.value_0;
    assign w_in_fields[1] = i_in.value_1;
    assign w_in_fields[2] = i_in.value_2;
    assign w_in_fields[3] = i_in.value_3;

    for (genvar d = 0; d < NUM_DIMS; d++) begin : g_vals
        if (d < psme_pkg::VALUE_FIELDS) begin : g_field
            assign w_in_vals[d] = w_in_fields[d];
        end else begin : g_zero
            assign w_in_vals[d] = '0;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= '0;
        end else if (i_cfg_we) begin
            r_lead <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= psme_pkg::t_action'(i_in.action);
            r_item   <= w_item_map[i_in.item];
            r_target <= w_tgt_map[i_in.target_part];
            r_vals   <= w_in_vals;
        end
    end

    psme_ram #(
        .WIDTH (PW),
        .DEPTH (ITEM_DEPTH)
    ) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (w_commit),
        .i_waddr (r_item),
        .i_wdata (w_chosen),
        .i_re    (w_accept),
        .i_raddr (w_item_map[i_in.item]),
        .o_rdata (w_cur)
    );

    always_comb begin
        w_placed = r_placed[r_item];
        w_status = psme_pkg::ST_DONE;
        w_chosen = '0;
        w_src    = '0;
        w_upd    = 1'b0;
        if (r_action == psme_pkg::ACT_PLACE) begin
            if (w_placed) begin
                w_status = psme_pkg::ST_PLACE_PLACED;
                w_chosen = w_cur;
            end else begin
                w_upd    = 1'b1;
                w_chosen = w_best;
            end
        end else begin
            if (!w_placed) begin
                w_status = psme_pkg::ST_MOVE_UNPLACED;
            end else begin
                w_upd    = 1'b1;
                w_chosen = r_target;
                w_src    = w_cur;
            end
        end
        w_commit = w_upd && (r_state == S_DEC);
        w_moved  = w_upd && (r_action == psme_pkg::ACT_MOVE);
        for (int p = 0; p < NUM_PARTS; p++) begin
            w_ctl[p].add = w_commit && (w_chosen == PW'(p));
            w_ctl[p].sub = w_commit && w_moved && (w_src == PW'(p));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ITEM_DEPTH; i++) begin
                r_placed[i] <= 1'b0;
            end
        end else if (w_commit) begin
            r_placed[r_item] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DEC) begin
            r_status <= w_status;
            r_chosen <= w_chosen;
            r_src    <= w_src;
            r_moved  <= w_moved;
        end
    end

    for (genvar p = 0; p < NUM_PARTS; p++) begin : g_lane
        psme_lane #(
            .NUM_DIMS (NUM_DIMS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[p]),
            .i_vals  (r_vals),
            .o_count (w_count[p]),
            .o_sum   (w_sums[p])
        );
    end

    psme_merge #(
        .NUM_PARTS (NUM_PARTS),
        .NUM_DIMS  (NUM_DIMS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_sums    (w_sums),
        .i_lead    (w_lead_map[r_lead]),
        .o_best    (w_best),
        .o_fitness (w_fitness)
    );

    assign w_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_accept) begin
                          n_state = S_DEC;
                      end
            S_DEC:    n_state = S_SETTLE;
            S_SETTLE: n_state = S_FIT;
            S_FIT:    n_state = S_DONE;
            S_DONE:   if (w_load) begin
                          n_state = S_IDLE;
                      end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status  <= r_status;
            r_out_chosen  <= psme_pkg::TGT_W'(r_chosen);
            r_out_src     <= psme_pkg::TGT_W'(r_src);
            r_out_count   <= r_moved ? w_count[r_src] : '0;
            r_out_fitness <= w_fitness;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.chosen_part  = r_out_chosen;
    assign o_out.source_part  = r_out_src;
    assign o_out.source_count = r_out_count;
    assign o_out.fitness      = r_out_fitness;

endmodule

// ===== design/psme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module psme_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/psme_lane.sv =====
// One part lane: item count and per-dimension sums with add/remove update.
module psme_lane #(
    parameter int NUM_DIMS = psme_pkg::DEF_NUM_DIMS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  psme_pkg::t_lane_ctl         i_ctl,
    input  logic [psme_pkg::VAL_W-1:0]  i_vals  [NUM_DIMS],
    output logic [psme_pkg::CNT_W-1:0]  o_count,
    output logic [psme_pkg::SUM_W-1:0]  o_sum   [NUM_DIMS]
);

    logic [psme_pkg::CNT_W-1:0] r_count;
    logic [psme_pkg::CNT_W-1:0] n_count;
    logic [psme_pkg::SUM_W-1:0] r_sum [NUM_DIMS];
    logic [psme_pkg::SUM_W-1:0] n_sum [NUM_DIMS];
    logic [psme_pkg::SUM_W-1:0] w_ext [NUM_DIMS];

    always_comb begin
        n_count = r_count + (i_ctl.add ? psme_pkg::CNT_W'(1) : '0)
                          - (i_ctl.sub ? psme_pkg::CNT_W'(1) : '0);
        for (int d = 0; d < NUM_DIMS; d++) begin
            w_ext[d] = psme_pkg::SUM_W'(i_vals[d]);
            n_sum[d] = r_sum[d] + (i_ctl.add ? w_ext[d] : '0)
                                - (i_ctl.sub ? w_ext[d] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int d = 0; d < NUM_DIMS; d++) begin
                r_sum[d] <= '0;
            end
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    assign o_count = r_count;
    assign o_sum   = r_sum;

endmodule

// ===== design/psme_merge.sv =====
// Merge of lane sums: registered min/max/argmin tree, then fitness stage.
module psme_merge #(
    parameter int NUM_PARTS = psme_pkg::DEF_NUM_PARTS,
    parameter int NUM_DIMS  = psme_pkg::DEF_NUM_DIMS
) (
    input  logic                          i_clk,
    input  logic [psme_pkg::SUM_W-1:0]    i_sums [NUM_PARTS][NUM_DIMS],
    input  logic [(NUM_DIMS > 1 ? $clog2(NUM_DIMS) : 1)-1:0] i_lead,
    output logic [$clog2(NUM_PARTS)-1:0]  o_best,
    output logic [psme_pkg::SUM_W-1:0]    o_fitness
);

    localparam int PW  = $clog2(NUM_PARTS);
    localparam int NP2 = 1 << PW;

    logic [psme_pkg::SUM_W-1:0] w_min  [PW+1][NUM_DIMS][NP2];
    logic [psme_pkg::SUM_W-1:0] w_max  [PW+1][NUM_DIMS][NP2];
    logic [psme_pkg::SUM_W-1:0] w_bval [PW+1][NP2];
    logic [PW-1:0]              w_bidx [PW+1][NP2];

    logic [psme_pkg::SUM_W-1:0] r_min [NUM_DIMS];
    logic [psme_pkg::SUM_W-1:0] r_max [NUM_DIMS];
    logic [PW-1:0]              r_best;
    logic [psme_pkg::SUM_W-1:0] w_diff;
    logic [psme_pkg::SUM_W-1:0] w_fit;
    logic [psme_pkg::SUM_W-1:0] r_fitness;

    // pad slots beyond NUM_PARTS copy part 0; ties keep the lower index
    always_comb begin
        int src;
        for (int l = 0; l <= PW; l++) begin
            for (int p = 0; p < NP2; p++) begin
                w_bval[l][p] = '0;
                w_bidx[l][p] = '0;
                for (int d = 0; d < NUM_DIMS; d++) begin
                    w_min[l][d][p] = '0;
                    w_max[l][d][p] = '0;
                end
            end
        end
        for (int p = 0; p < NP2; p++) begin
            src = (p < NUM_PARTS) ? p : 0;
            w_bval[0][p] = i_sums[src][i_lead];
            w_bidx[0][p] = PW'(src);
            for (int d = 0; d < NUM_DIMS; d++) begin
                w_min[0][d][p] = i_sums[src][d];
                w_max[0][d][p] = i_sums[src][d];
            end
        end
        for (int l = 0; l < PW; l++) begin
            for (int k = 0; k < (NP2 >> (l + 1)); k++) begin
                if (w_bval[l][2*k+1] < w_bval[l][2*k]) begin
                    w_bval[l+1][k] = w_bval[l][2*k+1];
                    w_bidx[l+1][k] = w_bidx[l][2*k+1];
                end else begin
                    w_bval[l+1][k] = w_bval[l][2*k];
                    w_bidx[l+1][k] = w_bidx[l][2*k];
                end
                for (int d = 0; d < NUM_DIMS; d++) begin
                    w_min[l+1][d][k] = (w_min[l][d][2*k+1] < w_min[l][d][2*k])
                                     ? w_min[l][d][2*k+1] : w_min[l][d][2*k];
                    w_max[l+1][d][k] = (w_max[l][d][2*k+1] > w_max[l][d][2*k])
                                     ? w_max[l][d][2*k+1] : w_max[l][d][2*k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= w_bidx[PW][0];
        for (int d = 0; d < NUM_DIMS; d++) begin
            r_min[d] <= w_min[PW][d][0];
            r_max[d] <= w_max[PW][d][0];
        end
    end

    always_comb begin
        w_fit  = '0;
        w_diff = '0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            w_diff = r_max[d] - r_min[d];
            if (w_diff > w_fit) begin
                w_fit = w_diff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fitness <= w_fit;
    end

    assign o_best    = r_best;
    assign o_fitness = r_fitness;

endmodule

// ===== test/partition_fitness_checker.sv =====
// Result checker for the partition sum move evaluator: mirrors part state and compares results.
module partition_fitness_checker
    import psme_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEAD_W-1:0] i_cfg_data,
    psme_in_if                i_in,
    psme_out_if               i_out,
    output int                o_fail_count,
    output int                o_outstanding,
    output int                o_checked
);

    localparam int N_ITEMS    = DEF_NUM_ITEMS;
    localparam int N_PARTS    = DEF_NUM_PARTS;
    localparam int N_DIMS     = DEF_NUM_DIMS;
    localparam int REPORT_CAP = 100;

    typedef logic [VALUE_FIELDS-1:0][VAL_W-1:0] t_values;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TGT_W-1:0]    chosen;
        logic [TGT_W-1:0]    from_part;
        logic [CNT_W-1:0]    from_count;
        logic [SUM_W-1:0]    fitness;
    } t_outcome;

    logic [LEAD_W-1:0] lead_dim;
    logic              placed     [N_ITEMS];
    logic [TGT_W-1:0]  home       [N_ITEMS];
    logic [CNT_W-1:0]  members    [N_PARTS];
    logic [SUM_W-1:0]  part_total [N_PARTS][N_DIMS];
    t_outcome          due_outcomes [$];

    function automatic logic [SUM_W-1:0] widest_spread();
        logic [SUM_W-1:0] lo, hi, widest;
        widest = '0;
        for (int d = 0; d < N_DIMS; d++) begin
            lo = part_total[0][d];
            hi = part_total[0][d];
            for (int p = 1; p < N_PARTS; p++) begin
                if (part_total[p][d] < lo) lo = part_total[p][d];
                if (part_total[p][d] > hi) hi = part_total[p][d];
            end
            if (hi - lo > widest) widest = hi - lo;
        end
        return widest;
    endfunction

    function automatic t_outcome apply_action(input logic act, input logic [ITEM_W-1:0] item_in,
                                              input logic [TGT_W-1:0] dest_in,
                                              input t_values vals);
        t_outcome         res;
        int               idx, dest, lead;
        logic [TGT_W-1:0] best, from;
        logic [VAL_W-1:0] v;
        res  = '0;
        idx  = item_in % N_ITEMS;
        dest = dest_in % N_PARTS;
        lead = lead_dim % N_DIMS;
        res.status = ST_DONE;
        if (act == ACT_PLACE) begin
            if (placed[idx]) begin
                res.status = ST_PLACE_PLACED;
                res.chosen = home[idx];
            end else begin
                best = '0;
                for (int p = 1; p < N_PARTS; p++)
                    if (part_total[p][lead] < part_total[best][lead]) best = TGT_W'(p);
                for (int d = 0; d < N_DIMS; d++) begin
                    v = (d < VALUE_FIELDS) ? vals[d] : '0;
                    part_total[best][d] = part_total[best][d] + v;
                end
                members[best] = members[best] + 1'b1;
                placed[idx]   = 1'b1;
                home[idx]     = best;
                res.chosen    = best;
            end
        end else if (!placed[idx]) begin
            res.status = ST_MOVE_UNPLACED;
        end else begin
            from          = home[idx];
            members[from] = members[from] - 1'b1;
            members[dest] = members[dest] + 1'b1;
            for (int d = 0; d < N_DIMS; d++) begin
                v = (d < VALUE_FIELDS) ? vals[d] : '0;
                part_total[from][d] = part_total[from][d] - v;
                part_total[dest][d] = part_total[dest][d] + v;
            end
            home[idx]      = TGT_W'(dest);
            res.chosen     = TGT_W'(dest);
            res.from_part  = from;
            res.from_count = members[from];
        end
        res.fitness = widest_spread();
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want, got;
        t_values  vals;
        if (!i_rst_n) begin
            lead_dim   = '0;
            placed     = '{default: 1'b0};
            home       = '{default: '0};
            members    = '{default: '0};
            part_total = '{default: '0};
            due_outcomes.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_cfg_we) lead_dim = i_cfg_data;
            if (i_out.valid && i_out.ready) begin
                got = {i_out.status, i_out.chosen_part, i_out.source_part,
                       i_out.source_count, i_out.fitness};
                if (due_outcomes.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_CAP)
                        $display("%0t: unexpected result: status %0d part %0d fitness %0d",
                                 $time, got.status, got.chosen, got.fitness);
                end else begin
                    want = due_outcomes.pop_front();
                    o_checked++;
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_CAP)
                            $display({"%0t: mismatch: expected status %0d part %0d src %0d ",
                                      "count %0d fitness %0d, got %0d %0d %0d %0d %0d"},
                                     $time, want.status, want.chosen, want.from_part,
                                     want.from_count, want.fitness, got.status, got.chosen,
                                     got.from_part, got.from_count, got.fitness);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                vals = {i_in.value_3, i_in.value_2, i_in.value_1, i_in.value_0};
                due_outcomes.push_back(apply_action(i_in.action, i_in.item, i_in.target_part,
                                                    vals));
            end
        end
        o_outstanding = due_outcomes.size();
    end

endmodule

// ===== test/tb.sv =====
// Testbench top: clock, reset, place and move stimulus in phases, and the verdict.
module tb;
    import psme_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int IDLE_LIMIT     = 3000;
    localparam int SETTLE         = 10;
    localparam int PHASE_ITEMS    = 366;
    localparam int N_PHASES       = 5;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES    = 150;
    localparam int N_ITEMS        = DEF_NUM_ITEMS;

    typedef logic [VALUE_FIELDS-1:0][VAL_W-1:0] t_values;

    int lead_plan  [N_PHASES] = '{3, 1, 2, 0, 3};
    int idle_plan  [N_PHASES] = '{0, 88, 0, 7, 0};
    int stall_plan [N_PHASES] = '{0, 0, 88, 7, 0};

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [LEAD_W-1:0] cfg_data;
    int                fail_count, outstanding, checked;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic rx_hold        = 1'b0;
    logic rx_hold_go     = 1'b0;
    int   idle_run       = 0;

    bit      known_placed [N_ITEMS];
    t_values known_vals   [N_ITEMS];
    int      n_unplaced = N_ITEMS;
    int      n_sent     = 0;
    int      n_place    = 0;
    int      n_move     = 0;

    psme_in_if  in_ch ();
    psme_out_if out_ch ();

    partition_sum_move_evaluator DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    partition_fitness_checker fitness_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    always #HALF_PERIOD clk = ~clk;

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (rx_hold_go);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, giving up", $time, IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(3))
            0:       return $urandom_range(1) ? {VAL_W{1'b1}} : {VAL_W{1'b0}};
            1:       return VAL_W'($urandom_range(3));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic t_values pick_values();
        t_values vals;
        for (int d = 0; d < VALUE_FIELDS; d++) vals[d] = pick_value();
        return vals;
    endfunction

    function automatic logic [ITEM_W-1:0] find_item(input bit want_placed);
        int start;
        start = $urandom_range(N_ITEMS - 1);
        for (int k = 0; k < N_ITEMS; k++)
            if (known_placed[(start + k) % N_ITEMS] == want_placed)
                return ITEM_W'((start + k) % N_ITEMS);
        return ITEM_W'(start);
    endfunction

    task automatic offer(input t_action act, input logic [ITEM_W-1:0] idx,
                         input logic [TGT_W-1:0] dest, input t_values vals);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.item        <= idx;
        in_ch.target_part <= dest;
        in_ch.value_0     <= vals[0];
        in_ch.value_1     <= vals[1];
        in_ch.value_2     <= vals[2];
        in_ch.value_3     <= vals[3];
        n_sent++;
        if (act == ACT_PLACE) n_place++;
        else n_move++;
        if (act == ACT_PLACE && !known_placed[idx]) begin
            known_placed[idx] = 1'b1;
            known_vals[idx]   = vals;
            n_unplaced--;
        end
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
    endtask

    // mostly legal places and moves carrying the placed values; some wrapping moves and noise
    task automatic random_action();
        int                r;
        logic [ITEM_W-1:0] idx;
        t_values           vals;
        r    = $urandom_range(99);
        vals = pick_values();
        if (r < 30 && n_unplaced > 0) begin
            offer(ACT_PLACE, find_item(1'b0), TGT_W'($urandom), vals);
        end else if (r < 88 && n_unplaced < N_ITEMS) begin
            idx = find_item(1'b1);
            offer(ACT_MOVE, idx, TGT_W'($urandom), (r < 82) ? known_vals[idx] : vals);
        end else begin
            offer(t_action'($urandom_range(1)), ITEM_W'($urandom), TGT_W'($urandom), vals);
        end
    endtask

    task automatic set_lead(input logic [LEAD_W-1:0] dim);
        cfg_we   <= 1'b1;
        cfg_data <= dim;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial begin
        t_values ones, zeros, mix;
        ones  = '1;
        zeros = '0;
        mix   = {16'h8000, 16'h0001, 16'h5555, 16'hAAAA};

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.action      <= ACT_PLACE;
        in_ch.item        <= '0;
        in_ch.target_part <= '0;
        in_ch.value_0     <= '0;
        in_ch.value_1     <= '0;
        in_ch.value_2     <= '0;
        in_ch.value_3     <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        set_lead('0);

        offer(ACT_MOVE, 8'd5, 3'd0, ones);       // move of unplaced item
        offer(ACT_PLACE, 8'd0, 3'd7, ones);      // all parts tied, target ignored
        offer(ACT_PLACE, 8'd0, 3'd0, zeros);     // already placed
        offer(ACT_MOVE, 8'd0, 3'd0, ones);       // move to own part
        offer(ACT_PLACE, 8'd255, 3'd0, zeros);
        for (int k = 1; k <= 6; k++)
            offer(ACT_PLACE, ITEM_W'(k), 3'd0, mix);
        offer(ACT_MOVE, 8'd255, 3'd7, ones);     // source sums wrap below zero
        offer(ACT_MOVE, 8'd0, 3'd7, ones);       // empties part 0
        offer(ACT_MOVE, 8'd255, 3'd3, ones);
        offer(ACT_MOVE, 8'd255, 3'd1, ones);     // wraps undone
        offer(ACT_PLACE, 8'd128, 3'd5, pick_values());
        offer(ACT_MOVE, 8'd77, 3'd7, zeros);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_lead(LEAD_W'(lead_plan[ph]));
            send_idle_pct  = idle_plan[ph];
            recv_stall_pct = stall_plan[ph];
            if (ph == PRESSURE_PHASE) rx_hold_go <= 1'b1;
            repeat (PHASE_ITEMS) random_action();
            drain();
        end

        $display("Ran %0d items (%0d places, %0d moves): directed cases, then %0d random phases",
                 n_sent, n_place, n_move, N_PHASES);
        $display("over lead dimensions 0-3 with gaps, stalls and a %0d-cycle hold-off; %0d checked",
                 HOLD_CYCLES, checked);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
